// File: rtl/hashed_key_counter_table_top_assert.svh
// assertion macros for the hashed key counter table
`ifndef HASHED_KEY_COUNTER_TABLE_TOP_ASSERT_SVH
`define HASHED_KEY_COUNTER_TABLE_TOP_ASSERT_SVH
// implication checked on every clock edge outside reset
`define HKC_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// implication checked in the clock cycle after the antecedent
`define HKC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: rtl/hkc_pkg.sv
// package with shared types and constants of the hashed key counter table
`timescale 1ns / 1ps
package hkc_pkg;
  localparam int unsigned KEY_W = 128;
  localparam int unsigned CNT_W = 64;
  localparam int unsigned LIM_W = 11;
  localparam logic [63:0] HASH_SEED = 64'd5381;

  localparam logic [1:0] ST_FOUND   = 2'd0;
  localparam logic [1:0] ST_ABSENT  = 2'd1;
  localparam logic [1:0] ST_REFUSED = 2'd2;

  localparam logic REQ_INC  = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // commands from controller to datapath
  typedef struct packed {
    logic load;       // capture request, start hashing
    logic hash_step;  // one key byte through the hash
    logic set_home;   // probe index from hash
    logic rd;         // issue memory read at probe index
    logic advance;    // probe index plus one
    logic wr_inc;     // write count plus one at probe index
    logic wr_new;     // write new key and count one
    logic clr;        // clearing pass write
    logic res_found;  // result: found
    logic res_absent; // result: absent
    logic res_refuse; // result: refused
  } hkc_cmd_t;

  typedef struct packed {
    logic hash_done;
    logic key_zero;
    logic is_read;
    logic hit;
    logic empty;
    logic probe_last;
    logic clr_last;
    logic room;
  } hkc_sts_t;

  // djb2 step: h*33 xor byte
  function automatic logic [63:0] djb2_step(input logic [63:0] h, input logic [7:0] c);
    djb2_step = ((h << 5) + h) ^ {56'd0, c};
  endfunction
endpackage

// File: rtl/hkc_datapath.sv
// datapath: request registers, hash unit, probe index, slot memories
`timescale 1ns / 1ps
module hkc_datapath #(
  parameter int unsigned SLOTS     = 1024,
  parameter int unsigned KEY_BYTES = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  hkc_pkg::hkc_cmd_t        cmd,
  output hkc_pkg::hkc_sts_t        sts,
  input  logic                     req_type,
  input  logic [63:0]              key_low,
  input  logic [63:0]              key_high,
  input  logic [hkc_pkg::LIM_W-1:0] insert_limit,
  output logic [63:0]              res_count,
  output logic [1:0]               res_status
);
  import hkc_pkg::*;
  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned BW = $clog2(KEY_BYTES + 1);
  localparam int unsigned UW = $clog2(SLOTS + 1);

  logic [KEY_W-1:0] key_mem [SLOTS];
  logic [CNT_W-1:0] cnt_mem [SLOTS];

  logic [KEY_W-1:0] key_r, key_nxt;
  logic             rtype_r;
  logic [63:0]      hash_r, hash_nxt;
  logic [KEY_W-1:0] shift_r, shift_nxt;
  logic [BW-1:0]    bcnt_r, bcnt_nxt;
  logic             hdone_r, hdone_nxt;
  logic [IW-1:0]    idx_r;
  logic [UW-1:0]    pcnt_r;
  logic [UW-1:0]    used_r;
  logic [KEY_W-1:0] rkey_r;
  logic [CNT_W-1:0] rcnt_r;
  logic [63:0]      rescnt_r;
  logic [1:0]       resst_r;
  logic [UW-1:0]    limit_eff;
  logic [KEY_W-1:0] in_key;

  always_comb begin
    in_key = {key_high, key_low};
    for (int b = 0; b < 16; b++) begin
      if (b >= KEY_BYTES) in_key[b*8 +: 8] = 8'd0;
    end
  end

  always_comb begin
    key_nxt   = key_r;
    hash_nxt  = hash_r;
    shift_nxt = shift_r;
    bcnt_nxt  = bcnt_r;
    hdone_nxt = hdone_r;
    if (cmd.load) begin
      key_nxt   = in_key;
      hash_nxt  = HASH_SEED;
      shift_nxt = in_key;
      bcnt_nxt  = '0;
      hdone_nxt = 1'b0;
    end else if (cmd.hash_step && !hdone_r) begin
      // stop at first zero byte or after the last key byte
      if (shift_r[7:0] == 8'd0 || bcnt_r == BW'(KEY_BYTES)) begin
        hdone_nxt = 1'b1;
      end else begin
        hash_nxt  = djb2_step(hash_r, shift_r[7:0]);
        shift_nxt = shift_r >> 8;
        bcnt_nxt  = bcnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    hash_r  <= hash_nxt;
    shift_r <= shift_nxt;
    bcnt_r  <= bcnt_nxt;
    if (cmd.load) rtype_r <= req_type;
    if (!rst_n) begin
      hdone_r <= 1'b0;
      used_r  <= '0;
      idx_r   <= '0;
      pcnt_r  <= '0;
    end else begin
      hdone_r <= hdone_nxt;
      if (cmd.set_home) begin
        idx_r  <= hash_r[IW-1:0];
        pcnt_r <= '0;
      end else if (cmd.advance || cmd.clr) begin
        idx_r  <= idx_r + 1'b1;
        pcnt_r <= pcnt_r + 1'b1;
      end
      if (cmd.wr_new) used_r <= used_r + 1'b1;
    end
  end

  // slot memories, registered read
  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      key_mem[idx_r] <= '0;
      cnt_mem[idx_r] <= '0;
    end else if (cmd.wr_new) begin
      key_mem[idx_r] <= key_r;
      cnt_mem[idx_r] <= CNT_W'(1);
    end else if (cmd.wr_inc) begin
      cnt_mem[idx_r] <= rcnt_r + 1'b1;
    end
    if (cmd.rd) begin
      rkey_r <= key_mem[idx_r];
      rcnt_r <= cnt_mem[idx_r];
    end
  end

  always_comb begin
    if (UW'(insert_limit) < UW'(SLOTS) && {1'b0, insert_limit} < (LIM_W+1)'(SLOTS))
      limit_eff = UW'(insert_limit);
    else
      limit_eff = UW'(SLOTS);
  end

  always_ff @(posedge clk) begin
    if (cmd.res_found) begin
      rescnt_r <= rcnt_r;
      resst_r  <= ST_FOUND;
    end else if (cmd.res_absent) begin
      rescnt_r <= '0;
      resst_r  <= ST_ABSENT;
    end else if (cmd.res_refuse) begin
      rescnt_r <= '0;
      resst_r  <= ST_REFUSED;
    end
  end

  assign res_count  = rescnt_r;
  assign res_status = resst_r;

  always_comb begin
    sts.hash_done  = hdone_r;
    sts.key_zero   = (key_r == '0);
    sts.is_read    = rtype_r;
    sts.hit        = (rkey_r == key_r);
    sts.empty      = (rkey_r == '0);
    sts.probe_last = (pcnt_r == UW'(SLOTS - 1));
    sts.clr_last   = (idx_r == IW'(SLOTS - 1));
    sts.room       = (used_r < limit_eff);
  end

  `include "hashed_key_counter_table_top_assert.svh"
  `HKC_ASSERT(a_used_bound, 1'b1, used_r <= UW'(SLOTS), "used slot count above table size")
  `HKC_ASSERT_NEXT(a_new_counts, cmd.wr_new, used_r == $past(used_r) + 1'b1, "insert not counted")
  `HKC_ASSERT(a_one_write, 1'b1, $onehot0({cmd.clr, cmd.wr_new, cmd.wr_inc}), "write clash")
endmodule

// File: rtl/hkc_ctrl.sv
// controller: clearing pass, hash, probe sequencing and result handshake
`timescale 1ns / 1ps
module hkc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output hkc_pkg::hkc_cmd_t cmd,
  input  hkc_pkg::hkc_sts_t sts
);
  import hkc_pkg::*;
  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_HASH, S_READ, S_WAIT, S_CHECK, S_OUT
  } state_t;

  state_t state_r;
  logic   ovalid_r;
  logic   accept;

  assign in_stall  = (state_r != S_IDLE) || ovalid_r;
  assign accept    = in_valid && !in_stall;
  assign out_valid = ovalid_r;

  always_comb begin
    cmd = '0;
    case (state_r)
      S_CLEAR: cmd.clr = 1'b1;
      S_IDLE:  cmd.load = accept;
      S_HASH: begin
        cmd.hash_step = 1'b1;
        cmd.set_home  = sts.hash_done;
      end
      S_READ: cmd.rd = 1'b1;
      S_WAIT: ;
      S_CHECK: begin
        if (sts.key_zero) begin
          cmd.res_absent = sts.is_read;
          cmd.res_refuse = !sts.is_read;
        end else if (sts.hit) begin
          cmd.res_found = 1'b1;
          cmd.wr_inc    = !sts.is_read;
        end else if (sts.empty || sts.probe_last) begin
          if (sts.is_read) begin
            cmd.res_absent = 1'b1;
          end else if (sts.empty && sts.room) begin
            cmd.res_absent = 1'b1;
            cmd.wr_new     = 1'b1;
          end else begin
            cmd.res_refuse = 1'b1;
          end
        end else begin
          cmd.advance = 1'b1;
        end
      end
      S_OUT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      ovalid_r <= 1'b0;
    end else begin
      if (ovalid_r && !out_stall) ovalid_r <= 1'b0;
      case (state_r)
        S_CLEAR: if (sts.clr_last) state_r <= S_IDLE;
        S_IDLE:  if (accept) state_r <= S_HASH;
        S_HASH:  if (sts.hash_done) state_r <= S_READ;
        S_READ:  state_r <= S_WAIT;
        S_WAIT:  state_r <= S_CHECK;
        S_CHECK: state_r <= cmd.advance ? S_READ : S_OUT;
        S_OUT: begin
          ovalid_r <= 1'b1;
          state_r  <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `include "hashed_key_counter_table_top_assert.svh"
  `HKC_ASSERT(a_no_accept_busy, ovalid_r, in_stall, "item taken while result pending")
  `HKC_ASSERT_NEXT(a_out_after, state_r == S_OUT, ovalid_r, "result not shown")
  `HKC_ASSERT(a_one_result, state_r == S_CHECK, $onehot0({cmd.res_found, cmd.res_absent, cmd.res_refuse}), "result clash")
endmodule

// File: rtl/hashed_key_counter_table_top.sv
// hashed key counter table: counts 128-bit keys in a linear-probed hash table
// channels: in_valid/in_stall with in_req_type, in_key_low, in_key_high;
//   out_valid/out_stall with out_count_value, out_status; cfg_we/cfg_wdata
//   writes insert_limit
// one item is worked at a time: hashing takes one nonzero key byte per cycle,
//   then makes an end check and sets the home slot index; each probed slot
//   then passes the memory read, registered data and compare states, then the
//   result is registered for out_valid; the item rate is bounded by the probe
//   loop over the slot memory's single port
// after reset a clearing pass over every slot zeroes the slot memories; no
//   item is taken during it, configuration writes are taken
// a result waits in the output register while out_stall is high; no new item
//   is taken until it has gone
`timescale 1ns / 1ps
module hashed_key_counter_table_top #(
  parameter int unsigned SLOTS     = 1024,
  parameter int unsigned KEY_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [63:0] in_key_low,
  input  logic [63:0] in_key_high,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_count_value,
  output logic [1:0]  out_status,
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata
);
  import hkc_pkg::*;
  hkc_cmd_t         cmd;
  hkc_sts_t         sts;
  logic [LIM_W-1:0] limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) limit_r <= LIM_W'((SLOTS * 8) / 10);
    else if (cfg_we) limit_r <= cfg_wdata;
  end

  hkc_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .cmd, .sts
  );

  hkc_datapath #(.SLOTS(SLOTS), .KEY_BYTES(KEY_BYTES)) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .req_type(in_req_type), .key_low(in_key_low), .key_high(in_key_high),
    .insert_limit(limit_r), .res_count(out_count_value), .res_status(out_status)
  );
endmodule

// File: tb/sv/hashed_key_counter_table_top_test.sv
// testbench for the hashed key counter table: randomized items checked against a table model
`timescale 1ns / 1ps
module hashed_key_counter_table_top_test;
  import hkc_pkg::*;

  localparam int unsigned NSLOTS   = 1024;
  localparam int unsigned POOL_N   = 48;
  localparam int unsigned IDLE_MAX = 20000;

  // mirror of the slot table with the queue of counts still to come back
  class count_table_board;
    logic [63:0] slot_lo  [NSLOTS];
    logic [63:0] slot_hi  [NSLOTS];
    logic [63:0] slot_cnt [NSLOTS];
    logic [10:0] used;
    logic [10:0] limit;
    logic [63:0] want_cnt [$];
    logic [1:0]  want_st  [$];
    int          errors;

    function new();
      for (int i = 0; i < NSLOTS; i++) begin
        slot_lo[i] = '0;
        slot_hi[i] = '0;
        slot_cnt[i] = '0;
      end
      used = '0;
      limit = 11'd819;
      errors = 0;
    endfunction

    function logic [63:0] djb2(logic [63:0] lo, logic [63:0] hi);
      logic [63:0] h;
      logic [7:0]  c;
      h = 64'd5381;
      for (int i = 0; i < 16; i++) begin
        c = (i < 8) ? lo[8*i +: 8] : hi[8*(i-8) +: 8];
        if (c == 8'd0) break;
        h = (h * 64'd33) ^ {56'd0, c};
      end
      return h;
    endfunction

    function void note(logic req, logic [63:0] lo, logic [63:0] hi);
      logic [9:0]  idx;
      logic [10:0] lim;
      bit          found;
      bit          empty;
      logic [63:0] cnt;
      logic [1:0]  st;
      found = 0;
      empty = 0;
      cnt = '0;
      st = ST_ABSENT;
      lim = (limit < NSLOTS) ? limit : 11'(NSLOTS);
      if (lo == 0 && hi == 0) begin
        st = (req == REQ_READ) ? ST_ABSENT : ST_REFUSED;
      end else begin
        idx = 10'(djb2(lo, hi) % NSLOTS);
        for (int n = 0; n < NSLOTS; n++) begin
          if (slot_lo[idx] == lo && slot_hi[idx] == hi) begin
            found = 1;
            break;
          end
          if (slot_lo[idx] == 0 && slot_hi[idx] == 0) begin
            empty = 1;
            break;
          end
          idx = idx + 10'd1;
        end
        if (found) begin
          cnt = slot_cnt[idx];
          st = ST_FOUND;
          if (req == REQ_INC) slot_cnt[idx] = slot_cnt[idx] + 64'd1;
        end else if (req == REQ_INC) begin
          if (!empty || used >= lim) begin
            st = ST_REFUSED;
          end else begin
            slot_lo[idx] = lo;
            slot_hi[idx] = hi;
            slot_cnt[idx] = 64'd1;
            used = used + 11'd1;
          end
        end
      end
      want_cnt.push_back(cnt);
      want_st.push_back(st);
    endfunction

    function void check(logic [63:0] cnt, logic [1:0] st);
      logic [63:0] ec;
      logic [1:0]  es;
      if (want_cnt.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected item: count %0h status %0d", cnt, st);
        return;
      end
      ec = want_cnt.pop_front();
      es = want_st.pop_front();
      if (ec !== cnt || es !== st) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected count %0h status %0d, got count %0h status %0d",
                   ec, es, cnt, st);
      end
    endfunction

    function int pending();
      return want_cnt.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_req_type;
  logic [63:0] in_key_low;
  logic [63:0] in_key_high;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] out_count_value;
  logic [1:0]  out_status;
  logic        cfg_we;
  logic [10:0] cfg_wdata;

  count_table_board board;
  bit          quiet;
  bit          res_taken;
  int          idle_cycles;
  logic [63:0] pool_lo [POOL_N];
  logic [63:0] pool_hi [POOL_N];

  hashed_key_counter_table_top #(.SLOTS(NSLOTS), .KEY_BYTES(16)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_req_type(in_req_type),
    .in_key_low(in_key_low), .in_key_high(in_key_high),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_count_value(out_count_value), .out_status(out_status),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function int pick_gap();
    return quiet ? 0 : $urandom_range(0, 4);
  endfunction

  // random key; prefix modes make keys that share a hash
  task automatic make_key(output logic [63:0] lo, output logic [63:0] hi);
    logic [127:0] k;
    int           len;
    int           mode;
    k = '0;
    mode = $urandom_range(0, 3);
    len = $urandom_range(1, 15);
    case (mode)
      0: begin
        k = {$urandom, $urandom, $urandom, $urandom};
      end
      1: begin
        for (int i = 0; i < 16; i++) if (i <= len) k[8*i +: 8] = 8'($urandom_range(1, 255));
      end
      2: begin
        for (int i = 0; i < 16; i++) begin
          if (i < len) k[8*i +: 8] = 8'($urandom_range(1, 255));
          else if (i > len) k[8*i +: 8] = 8'($urandom);
        end
        if (k == 0) k[0 +: 8] = 8'd7;
      end
      default: begin
        k[127:64] = {$urandom, $urandom};
      end
    endcase
    lo = k[63:0];
    hi = k[127:64];
  endtask

  // valid stays high after acceptance so back-to-back items never drop it
  task automatic send_item(logic req, logic [63:0] lo, logic [63:0] hi);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_key_low <= lo;
    in_key_high <= hi;
    do @(posedge clk); while (in_stall);
    board.note(req, lo, hi);
    @(negedge clk);
  endtask

  task automatic write_limit(logic [10:0] v);
    in_valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    board.limit = v;
  endtask

  task automatic random_items(int num);
    logic [63:0] lo;
    logic [63:0] hi;
    int          pick;
    int          p;
    for (int n = 0; n < num; n++) begin
      if (n % 100 == 0) quiet = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        p = $urandom_range(0, POOL_N - 1);
        lo = pool_lo[p];
        hi = pool_hi[p];
      end else if (pick < 95) begin
        make_key(lo, hi);
      end else begin
        lo = '0;
        hi = '0;
      end
      send_item((($urandom_range(0, 9) < 6) ? REQ_INC : REQ_READ), lo, hi);
    end
    quiet = 0;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      board.check(out_count_value, out_status);
      res_taken = 1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_MAX) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (res_taken) begin
        res_taken = 0;
        n = pick_gap();
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(negedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  initial begin
    logic [63:0] lo;
    logic [63:0] hi;
    board = new();
    quiet = 0;
    res_taken = 0;
    idle_cycles = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = REQ_INC;
    in_key_low = '0;
    in_key_high = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    for (int i = 0; i < POOL_N; i++) make_key(pool_lo[i], pool_hi[i]);
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // reset limit lets the first key in
    send_item(REQ_INC, 64'h41, 64'h0);
    send_item(REQ_READ, 64'h41, 64'h0);
    // zero limit: new keys refused, existing keys still count
    write_limit(11'd0);
    send_item(REQ_INC, 64'h0042_4242, 64'h0);
    send_item(REQ_INC, 64'h41, 64'h0);
    send_item(REQ_READ, 64'h0042_4242, 64'h0);
    send_item(REQ_INC, 64'h0, 64'h0);
    send_item(REQ_READ, 64'h0, 64'h0);
    write_limit(11'd1);
    send_item(REQ_INC, 64'h0042_4242, 64'h0);
    send_item(REQ_INC, '1, '1);
    write_limit(11'd2);
    send_item(REQ_INC, 64'h0042_4242, 64'h0);
    // same hash as the key before, differs after the zero byte
    send_item(REQ_INC, 64'h0099_0042_4242, 64'h0);
    // limit above the slot count
    write_limit(11'd2047);
    send_item(REQ_INC, 64'h0099_0042_4242, 64'h0);
    send_item(REQ_READ, 64'h0099_0042_4242, 64'h0);
    send_item(REQ_READ, 64'h0042_4242, 64'h0);
    send_item(REQ_INC, 64'h0, 64'h1);
    send_item(REQ_INC, 64'h0, 64'hFFFF_0000_0000_0000);
    send_item(REQ_READ, 64'h0, 64'h1);
    send_item(REQ_INC, 64'h0, 64'h1);
    send_item(REQ_INC, '1, '1);
    send_item(REQ_READ, '1, '1);
    send_item(REQ_INC, 64'h1, 64'h0);

    write_limit(11'd300);
    random_items(250);
    write_limit(11'd2047);
    random_items(300);

    // fill every slot, then probe a full table
    write_limit(11'd1024);
    while (board.used < NSLOTS) begin
      make_key(lo, hi);
      send_item(REQ_INC, lo, hi);
    end
    for (int i = 0; i < 8; i++) begin
      make_key(lo, hi);
      send_item(((i % 2) ? REQ_READ : REQ_INC), lo, hi);
      send_item(REQ_INC, pool_lo[i], pool_hi[i]);
    end

    in_valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (board.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

// File: files.f
+incdir+rtl
rtl/hkc_pkg.sv
rtl/hkc_datapath.sv
rtl/hkc_ctrl.sv
rtl/hashed_key_counter_table_top.sv
tb/sv/hashed_key_counter_table_top_test.sv
